// ----- rtl/pn2d_pkg.sv -----
// ----------------------------------------------------------------------------
// pn2d_pkg
// Shared constants for the 2D gradient noise point evaluator.
// ----------------------------------------------------------------------------
package pn2d_pkg;

   // defaults for the top-level parameters
   localparam int TABLE_SIZE_DEF  = 512;
   localparam int COORD_BITS_DEF  = 16;
   localparam int FRAC_BITS_DEF   = 16;

   // fixed field widths
   localparam int DENS_W          = 16;
   localparam int NOISE_W         = 16;

   // entries in the queue between front and back
   localparam int QUEUE_DEPTH     = 4;

   localparam logic [DENS_W-1:0] DENS_RESET = 16'd1;

   // request commands
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_EVAL = 1'b1;

endpackage

// ----- rtl/pn2d_ram.sv -----
// ----------------------------------------------------------------------------
// pn2d_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pn2d_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/pn2d_front.sv -----
// ----------------------------------------------------------------------------
// pn2d_front
// Accepts requests, folds the load index into the table range and queues
// items for the back pipeline.
// ----------------------------------------------------------------------------
module pn2d_front #(
   parameter int TABLE_SIZE = pn2d_pkg::TABLE_SIZE_DEF,
   parameter int COORD_BITS = pn2d_pkg::COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_command,
   input  logic [$clog2(TABLE_SIZE)-1:0] req_table_index,
   input  logic [$clog2(TABLE_SIZE)-1:0] req_table_value,
   input  logic [COORD_BITS-1:0]         req_coord_x,
   input  logic [COORD_BITS-1:0]         req_coord_y,
   output logic                          head_valid,
   input  logic                          head_pop,
   output logic                          head_command,
   output logic [$clog2(TABLE_SIZE)-1:0] head_index,
   output logic [$clog2(TABLE_SIZE)-1:0] head_value,
   output logic [COORD_BITS-1:0]         head_x,
   output logic [COORD_BITS-1:0]         head_y
);
   import pn2d_pkg::*;

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [IDX_W:0] TSZ = (IDX_W+1)'(TABLE_SIZE);

   logic                  q_cmd_ff [QUEUE_DEPTH];
   logic [IDX_W-1:0]      q_idx_ff [QUEUE_DEPTH];
   logic [IDX_W-1:0]      q_val_ff [QUEUE_DEPTH];
   logic [COORD_BITS-1:0] q_x_ff   [QUEUE_DEPTH];
   logic [COORD_BITS-1:0] q_y_ff   [QUEUE_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  push;
   logic                  pop;
   logic [IDX_W:0]        idx_ext;
   logic [IDX_W-1:0]      idx_wrap;

   assign req_ready  = (cnt_ff != CNT_W'(QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign push       = req_valid && req_ready;
   assign pop        = head_pop && head_valid;

   // fold an index past the table end back into range
   always_comb begin
      idx_ext  = {1'b0, req_table_index};
      idx_wrap = (idx_ext >= TSZ) ? IDX_W'(idx_ext - TSZ) : req_table_index;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_cmd_ff[wr_ptr_ff] <= req_command;
         q_idx_ff[wr_ptr_ff] <= idx_wrap;
         q_val_ff[wr_ptr_ff] <= req_table_value;
         q_x_ff[wr_ptr_ff]   <= req_coord_x;
         q_y_ff[wr_ptr_ff]   <= req_coord_y;
      end
   end

   assign head_command = q_cmd_ff[rd_ptr_ff];
   assign head_index   = q_idx_ff[rd_ptr_ff];
   assign head_value   = q_val_ff[rd_ptr_ff];
   assign head_x       = q_x_ff[rd_ptr_ff];
   assign head_y       = q_y_ff[rd_ptr_ff];

endmodule

// ----- rtl/pn2d_divider.sv -----
// ----------------------------------------------------------------------------
// pn2d_divider
// Pipelined restoring divider, one quotient bit per stage. Divides
// coord * 2^FRAC_BITS by the cell density; the integer quotient is reduced
// modulo the table size as it forms, the low bits are the cell fraction.
// ----------------------------------------------------------------------------
module pn2d_divider #(
   parameter int TABLE_SIZE = pn2d_pkg::TABLE_SIZE_DEF,
   parameter int COORD_BITS = pn2d_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = pn2d_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          enable,
   input  logic [COORD_BITS-1:0]         coord,
   input  logic [pn2d_pkg::DENS_W-1:0]   density,
   output logic [$clog2(TABLE_SIZE)-1:0] cell_idx,
   output logic [FRAC_BITS-1:0]          frac
);
   import pn2d_pkg::*;

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam int N     = COORD_BITS + FRAC_BITS;
   localparam int RW    = DENS_W + 1;
   localparam logic [IDX_W:0] TSZ = (IDX_W+1)'(TABLE_SIZE);

   logic [RW-1:0]         rem_ff  [N];
   logic [IDX_W-1:0]      cell_ff [N];
   logic [FRAC_BITS-1:0]  frac_ff [N];
   logic [COORD_BITS-1:0] dvd_ff  [N];
   logic [RW-1:0]         divisor;

   // zero density acts as one
   assign divisor = (density == '0) ? RW'(1) : {1'b0, density};

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic [RW-1:0]         rem_p, trial, rem_in;
      logic [IDX_W-1:0]      cell_p, cell_in;
      logic [FRAC_BITS-1:0]  frac_p, frac_in;
      logic [COORD_BITS-1:0] dvd_p, dvd_in;
      logic [IDX_W:0]        cell_sh;
      logic                  qbit;

      if (k == 0) begin : g_first
         assign rem_p  = '0;
         assign cell_p = '0;
         assign frac_p = '0;
         assign dvd_p  = coord;
      end else begin : g_next
         assign rem_p  = rem_ff[k-1];
         assign cell_p = cell_ff[k-1];
         assign frac_p = frac_ff[k-1];
         assign dvd_p  = dvd_ff[k-1];
      end

      always_comb begin
         trial   = {rem_p[RW-2:0], dvd_p[COORD_BITS-1]};
         qbit    = (trial >= divisor);
         rem_in  = qbit ? trial - divisor : trial;
         dvd_in  = {dvd_p[COORD_BITS-2:0], 1'b0};
         cell_sh = {cell_p, qbit};
         cell_in = cell_p;
         frac_in = frac_p;
         if (k < COORD_BITS) begin
            // integer quotient bit: keep the cell reduced modulo the table
            cell_in = (cell_sh >= TSZ) ? IDX_W'(cell_sh - TSZ) : cell_sh[IDX_W-1:0];
         end else begin
            frac_in = {frac_p[FRAC_BITS-2:0], qbit};
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k]  <= rem_in;
            cell_ff[k] <= cell_in;
            frac_ff[k] <= frac_in;
            dvd_ff[k]  <= dvd_in;
         end
      end
   end

   assign cell_idx = cell_ff[N-1];
   assign frac     = frac_ff[N-1];

endmodule

// ----- rtl/pn2d_back.sv -----
// ----------------------------------------------------------------------------
// pn2d_back
// Back pipeline: cell division, permutation hashing, gradient dot products,
// quintic fade, bilinear blend and output scaling. Table loads travel the
// same pipe and write each table copy at the stage where that copy is read.
// ----------------------------------------------------------------------------
module pn2d_back #(
   parameter int TABLE_SIZE = pn2d_pkg::TABLE_SIZE_DEF,
   parameter int COORD_BITS = pn2d_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = pn2d_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          head_valid,
   output logic                          head_pop,
   input  logic                          head_command,
   input  logic [$clog2(TABLE_SIZE)-1:0] head_index,
   input  logic [$clog2(TABLE_SIZE)-1:0] head_value,
   input  logic [COORD_BITS-1:0]         head_x,
   input  logic [COORD_BITS-1:0]         head_y,
   input  logic [pn2d_pkg::DENS_W-1:0]   density,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [pn2d_pkg::NOISE_W-1:0]  rsp_noise_value
);
   import pn2d_pkg::*;

   localparam int F     = FRAC_BITS;
   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam int N     = COORD_BITS + FRAC_BITS;
   localparam int PW    = 2*F + 3;     // scaled diagonal terms
   localparam int DW    = F + 4;       // dot products and blends
   localparam int FP_W  = 2*F + 7;     // first fade product
   localparam int FU_W  = 2*F + 4;     // later fade products
   localparam int MW    = 2*F + 7;     // blend products
   localparam int SHR   = (F >= 15) ? F - 15 : 0;
   localparam int SHL   = (F < 15) ? 15 - F : 0;
   localparam int SW    = DW + SHL;
   localparam longint DIAG = ((longint'(71) << F) + 50) / 100;

   localparam logic [F-1:0]             DIAG_C  = F'(DIAG);
   localparam logic signed [PW-1:0]     DIAG_SH = PW'(DIAG << F);
   localparam logic signed [F+1:0]      ONE_D   = (F+2)'(longint'(1) << F);
   localparam logic signed [FP_W-1:0]   TEN     = FP_W'(longint'(10) << F);
   localparam logic [IDX_W:0]           TSZ     = (IDX_W+1)'(TABLE_SIZE);
   localparam logic signed [SW-1:0]     SAT_HI  = SW'(32767);
   localparam logic signed [SW-1:0]     SAT_LO  = SW'(-32768);

   // gradient codes (low three bits of the hash)
   localparam logic [2:0] G_NN = 3'd0;
   localparam logic [2:0] G_PN = 3'd1;
   localparam logic [2:0] G_NP = 3'd2;
   localparam logic [2:0] G_PP = 3'd3;
   localparam logic [2:0] G_NX = 3'd4;
   localparam logic [2:0] G_PX = 3'd5;
   localparam logic [2:0] G_PY = 3'd6;
   localparam logic [2:0] G_NY = 3'd7;

   function automatic logic [IDX_W-1:0] hash_mod(input logic [IDX_W-1:0] p,
                                                 input logic [IDX_W:0]   y);
      logic [IDX_W+1:0] s;
      logic [IDX_W+1:0] m;
      m = {1'b0, TSZ};
      s = {2'b00, p} + {1'b0, y};
      if (s >= m) s = s - m;
      if (s >= m) s = s - m;
      return s[IDX_W-1:0];
   endfunction

   function automatic logic signed [FP_W-1:0] fade_first(input logic [F-1:0] t);
      logic signed [F+5:0] s;
      s = $signed((F+6)'(t) * (F+6)'(6)) - $signed((F+6)'(15) << F);
      return s * $signed({1'b0, t});
   endfunction

   function automatic logic signed [DW-1:0] corner_dot(
      input logic [2:0]             h,
      input logic signed [F+1:0]    dx,
      input logic signed [F+1:0]    dy,
      input logic signed [PW-1:0]   dxd,
      input logic signed [PW-1:0]   dyd);
      logic signed [PW-1:0] s;
      logic signed [DW-1:0] r;
      s = '0;
      r = '0;
      unique case (h)
         G_NN: s = -dxd - dyd;
         G_PN: s = dxd - dyd;
         G_NP: s = dyd - dxd;
         G_PP: s = dxd + dyd;
         G_NX: r = -DW'(dx);
         G_PX: r = DW'(dx);
         G_PY: r = DW'(dy);
         G_NY: r = -DW'(dy);
         default: r = '0;
      endcase
      if (h == G_NN || h == G_PN || h == G_NP || h == G_PP) begin
         r = DW'(s >>> F);
      end
      return r;
   endfunction

   logic adv;
   logic rsp_valid_ff;

   // ---------------- item tags through the divider ----------------
   logic             tag_vld_ff [N];
   logic             tag_cmd_ff [N];
   logic [IDX_W-1:0] tag_idx_ff [N];
   logic [IDX_W-1:0] tag_val_ff [N];

   // advance the whole pipe unless a finished result is held
   assign adv      = !rsp_valid_ff || rsp_ready;
   assign head_pop = adv && head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < N; k++) tag_vld_ff[k] <= 1'b0;
      end else if (adv) begin
         tag_vld_ff[0] <= head_valid;
         for (int k = 1; k < N; k++) tag_vld_ff[k] <= tag_vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tag_cmd_ff[0] <= head_command;
         tag_idx_ff[0] <= head_index;
         tag_val_ff[0] <= head_value;
         for (int k = 1; k < N; k++) begin
            tag_cmd_ff[k] <= tag_cmd_ff[k-1];
            tag_idx_ff[k] <= tag_idx_ff[k-1];
            tag_val_ff[k] <= tag_val_ff[k-1];
         end
      end
   end

   logic [IDX_W-1:0] cell_x, cell_y;
   logic [F-1:0]     frac_x, frac_y;

   pn2d_divider #(
      .TABLE_SIZE (TABLE_SIZE),
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_div_x (
      .clock    (clock),
      .enable   (adv),
      .coord    (head_x),
      .density  (density),
      .cell_idx (cell_x),
      .frac     (frac_x)
   );

   pn2d_divider #(
      .TABLE_SIZE (TABLE_SIZE),
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_div_y (
      .clock    (clock),
      .enable   (adv),
      .coord    (head_y),
      .density  (density),
      .cell_idx (cell_y),
      .frac     (frac_y)
   );

   // ---------------- stage A: first table lookups ----------------
   logic             n_load;
   logic [IDX_W:0]   x1_sum;
   logic [IDX_W-1:0] x1;
   logic [IDX_W-1:0] px0, px1;

   assign n_load = adv && tag_vld_ff[N-1] && (tag_cmd_ff[N-1] == CMD_LOAD);
   assign x1_sum = {1'b0, cell_x} + 1'b1;
   assign x1     = (x1_sum == TSZ) ? '0 : x1_sum[IDX_W-1:0];

   pn2d_ram #(.WIDTH(IDX_W), .DEPTH(TABLE_SIZE)) u_perm_x0 (
      .clock   (clock),
      .wr_en   (n_load),
      .wr_addr (tag_idx_ff[N-1]),
      .wr_data (tag_val_ff[N-1]),
      .rd_en   (adv),
      .rd_addr (cell_x),
      .rd_data (px0)
   );

   pn2d_ram #(.WIDTH(IDX_W), .DEPTH(TABLE_SIZE)) u_perm_x1 (
      .clock   (clock),
      .wr_en   (n_load),
      .wr_addr (tag_idx_ff[N-1]),
      .wr_data (tag_val_ff[N-1]),
      .rd_en   (adv),
      .rd_addr (x1),
      .rd_data (px1)
   );

   logic                   a_vld_ff;
   logic                   a_cmd_ff;
   logic [IDX_W-1:0]       a_idx_ff, a_val_ff;
   logic [IDX_W-1:0]       a_y0_ff;
   logic [IDX_W:0]         a_y1_ff;
   logic [F-1:0]           a_tx_ff, a_ty_ff;
   logic [2*F-1:0]         a_txd_ff, a_tyd_ff;
   logic signed [FP_W-1:0] a_fx_ff, a_fy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= tag_vld_ff[N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_cmd_ff <= tag_cmd_ff[N-1];
         a_idx_ff <= tag_idx_ff[N-1];
         a_val_ff <= tag_val_ff[N-1];
         a_y0_ff  <= cell_y;
         a_y1_ff  <= {1'b0, cell_y} + 1'b1;
         a_tx_ff  <= frac_x;
         a_ty_ff  <= frac_y;
         a_txd_ff <= frac_x * DIAG_C;
         a_tyd_ff <= frac_y * DIAG_C;
         a_fx_ff  <= fade_first(frac_x);
         a_fy_ff  <= fade_first(frac_y);
      end
   end

   // ---------------- stage B: corner hash lookups ----------------
   logic             a_load;
   logic [IDX_W-1:0] h_bl, h_br, h_tl, h_tr;
   logic [IDX_W-1:0] addr_bl, addr_br, addr_tl, addr_tr;
   logic signed [FP_W-1:0] p1x_w, p1y_w;

   assign a_load  = adv && a_vld_ff && (a_cmd_ff == CMD_LOAD);
   assign addr_bl = hash_mod(px0, {1'b0, a_y0_ff});
   assign addr_br = hash_mod(px1, {1'b0, a_y0_ff});
   assign addr_tl = hash_mod(px0, a_y1_ff);
   assign addr_tr = hash_mod(px1, a_y1_ff);

   pn2d_ram #(.WIDTH(IDX_W), .DEPTH(TABLE_SIZE)) u_perm_bl (
      .clock (clock), .wr_en (a_load), .wr_addr (a_idx_ff), .wr_data (a_val_ff),
      .rd_en (adv), .rd_addr (addr_bl), .rd_data (h_bl)
   );

   pn2d_ram #(.WIDTH(IDX_W), .DEPTH(TABLE_SIZE)) u_perm_br (
      .clock (clock), .wr_en (a_load), .wr_addr (a_idx_ff), .wr_data (a_val_ff),
      .rd_en (adv), .rd_addr (addr_br), .rd_data (h_br)
   );

   pn2d_ram #(.WIDTH(IDX_W), .DEPTH(TABLE_SIZE)) u_perm_tl (
      .clock (clock), .wr_en (a_load), .wr_addr (a_idx_ff), .wr_data (a_val_ff),
      .rd_en (adv), .rd_addr (addr_tl), .rd_data (h_tl)
   );

   pn2d_ram #(.WIDTH(IDX_W), .DEPTH(TABLE_SIZE)) u_perm_tr (
      .clock (clock), .wr_en (a_load), .wr_addr (a_idx_ff), .wr_data (a_val_ff),
      .rd_en (adv), .rd_addr (addr_tr), .rd_data (h_tr)
   );

   assign p1x_w = (a_fx_ff >>> F) + TEN;
   assign p1y_w = (a_fy_ff >>> F) + TEN;

   logic           b_ev_ff;
   logic [F-1:0]   b_tx_ff, b_ty_ff;
   logic [2*F-1:0] b_txd_ff, b_tyd_ff;
   logic [FU_W-1:0] b_fx_ff, b_fy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ev_ff <= 1'b0;
      end else if (adv) begin
         b_ev_ff <= a_vld_ff && (a_cmd_ff == CMD_EVAL);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_tx_ff  <= a_tx_ff;
         b_ty_ff  <= a_ty_ff;
         b_txd_ff <= a_txd_ff;
         b_tyd_ff <= a_tyd_ff;
         b_fx_ff  <= p1x_w[F+3:0] * a_tx_ff;
         b_fy_ff  <= p1y_w[F+3:0] * a_ty_ff;
      end
   end

   // ---------------- stage C: gradient dot products ----------------
   logic signed [F+1:0]  dx0, dx1, dy0, dy1;
   logic signed [PW-1:0] dxd0, dxd1, dyd0, dyd1;

   always_comb begin
      dx0  = (F+2)'(b_tx_ff);
      dy0  = (F+2)'(b_ty_ff);
      dx1  = dx0 - ONE_D;
      dy1  = dy0 - ONE_D;
      dxd0 = PW'(b_txd_ff);
      dyd0 = PW'(b_tyd_ff);
      dxd1 = dxd0 - DIAG_SH;
      dyd1 = dyd0 - DIAG_SH;
   end

   logic                 c_ev_ff;
   logic [F-1:0]         c_tx_ff, c_ty_ff;
   logic [FU_W-1:0]      c_fx_ff, c_fy_ff;
   logic signed [DW-1:0] c_bl_ff, c_br_ff, c_tl_ff, c_tr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ev_ff <= 1'b0;
      end else if (adv) begin
         c_ev_ff <= b_ev_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_tx_ff <= b_tx_ff;
         c_ty_ff <= b_ty_ff;
         c_fx_ff <= b_fx_ff[FU_W-1:F] * b_tx_ff;
         c_fy_ff <= b_fy_ff[FU_W-1:F] * b_ty_ff;
         c_bl_ff <= corner_dot(h_bl[2:0], dx0, dy0, dxd0, dyd0);
         c_br_ff <= corner_dot(h_br[2:0], dx1, dy0, dxd1, dyd0);
         c_tl_ff <= corner_dot(h_tl[2:0], dx0, dy1, dxd0, dyd1);
         c_tr_ff <= corner_dot(h_tr[2:0], dx1, dy1, dxd1, dyd1);
      end
   end

   // ---------------- stage D: last fade product ----------------
   logic                 d_ev_ff;
   logic [FU_W-1:0]      d_fx_ff, d_fy_ff;
   logic signed [DW-1:0] d_bl_ff, d_br_ff, d_tl_ff, d_tr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ev_ff <= 1'b0;
      end else if (adv) begin
         d_ev_ff <= c_ev_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_fx_ff <= c_fx_ff[FU_W-1:F] * c_tx_ff;
         d_fy_ff <= c_fy_ff[FU_W-1:F] * c_ty_ff;
         d_bl_ff <= c_bl_ff;
         d_br_ff <= c_br_ff;
         d_tl_ff <= c_tl_ff;
         d_tr_ff <= c_tr_ff;
      end
   end

   // ---------------- stage E: blend along y ----------------
   logic [F:0]         fade_u, fade_v;
   logic signed [DW:0] diff_l, diff_r;

   always_comb begin
      fade_u = d_fx_ff[2*F:F];
      fade_v = d_fy_ff[2*F:F];
      diff_l = (DW+1)'(d_tl_ff) - (DW+1)'(d_bl_ff);
      diff_r = (DW+1)'(d_tr_ff) - (DW+1)'(d_br_ff);
   end

   logic                 e_ev_ff;
   logic [F:0]           e_u_ff;
   logic signed [DW-1:0] e_bl_ff, e_br_ff;
   logic signed [MW-1:0] e_ml_ff, e_mr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_ev_ff <= 1'b0;
      end else if (adv) begin
         e_ev_ff <= d_ev_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_u_ff  <= fade_u;
         e_bl_ff <= d_bl_ff;
         e_br_ff <= d_br_ff;
         e_ml_ff <= $signed({1'b0, fade_v}) * diff_l;
         e_mr_ff <= $signed({1'b0, fade_v}) * diff_r;
      end
   end

   // ---------------- stage F: blend along x ----------------
   logic signed [DW-1:0] lerp_l, lerp_r;
   logic signed [DW:0]   diff_x;

   always_comb begin
      lerp_l = e_bl_ff + DW'(e_ml_ff >>> F);
      lerp_r = e_br_ff + DW'(e_mr_ff >>> F);
      diff_x = (DW+1)'(lerp_r) - (DW+1)'(lerp_l);
   end

   logic                 f_ev_ff;
   logic signed [DW-1:0] f_l_ff;
   logic signed [MW-1:0] f_m_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_ev_ff <= 1'b0;
      end else if (adv) begin
         f_ev_ff <= e_ev_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_l_ff <= lerp_l;
         f_m_ff <= $signed({1'b0, e_u_ff}) * diff_x;
      end
   end

   // ---------------- output: scale to Q1.15 and saturate ----------------
   logic signed [DW-1:0]    noise_raw;
   logic signed [SW-1:0]    noise_sc;
   logic [NOISE_W-1:0]      noise_sat;
   logic [NOISE_W-1:0]      rsp_noise_value_ff;

   always_comb begin
      noise_raw = f_l_ff + DW'(f_m_ff >>> F);
      noise_sc  = (F >= 15) ? (SW'(noise_raw) >>> SHR) : (SW'(noise_raw) <<< SHL);
      if (noise_sc > SAT_HI) begin
         noise_sat = NOISE_W'(SAT_HI);
      end else if (noise_sc < SAT_LO) begin
         noise_sat = NOISE_W'(SAT_LO);
      end else begin
         noise_sat = noise_sc[NOISE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= f_ev_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_noise_value_ff <= noise_sat;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_noise_value_ff;

endmodule

// ----- rtl/perlin_noise_2d_point_top.sv -----
// ----------------------------------------------------------------------------
// perlin_noise_2d_point_top
// 2D gradient noise at integer coordinates, with a loadable permutation table.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    command, table_index,
//                                              table_value, coord_x, coord_y
//   rsp      out        rsp_valid/rsp_ready    noise_value (signed Q1.15)
//   csr      in         csr_valid/csr_ready    cell_density
//
// One item per cycle sustained while results are taken. Loads produce no
// result. Reset sets the density to one; the permutation table holds no
// defined value until loaded. A held result freezes the back pipeline while
// the four-entry queue keeps taking requests until it is full.
// ----------------------------------------------------------------------------
module perlin_noise_2d_point_top #(
   parameter int TABLE_SIZE = pn2d_pkg::TABLE_SIZE_DEF,
   parameter int COORD_BITS = pn2d_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = pn2d_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_command,
   input  logic [$clog2(TABLE_SIZE)-1:0] req_table_index,
   input  logic [$clog2(TABLE_SIZE)-1:0] req_table_value,
   input  logic [COORD_BITS-1:0]         req_coord_x,
   input  logic [COORD_BITS-1:0]         req_coord_y,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [pn2d_pkg::NOISE_W-1:0]  rsp_noise_value,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [pn2d_pkg::DENS_W-1:0]   csr_cell_density
);
   import pn2d_pkg::*;

   localparam int IDX_W = $clog2(TABLE_SIZE);

   logic [DENS_W-1:0]     density_ff;
   logic                  head_valid;
   logic                  head_pop;
   logic                  head_command;
   logic [IDX_W-1:0]      head_index;
   logic [IDX_W-1:0]      head_value;
   logic [COORD_BITS-1:0] head_x;
   logic [COORD_BITS-1:0] head_y;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         density_ff <= DENS_RESET;
      end else if (csr_valid && csr_ready) begin
         density_ff <= csr_cell_density;
      end
   end

   pn2d_front #(
      .TABLE_SIZE (TABLE_SIZE),
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_table_index (req_table_index),
      .req_table_value (req_table_value),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .head_valid      (head_valid),
      .head_pop        (head_pop),
      .head_command    (head_command),
      .head_index      (head_index),
      .head_value      (head_value),
      .head_x          (head_x),
      .head_y          (head_y)
   );

   pn2d_back #(
      .TABLE_SIZE (TABLE_SIZE),
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_pop        (head_pop),
      .head_command    (head_command),
      .head_index      (head_index),
      .head_value      (head_value),
      .head_x          (head_x),
      .head_y          (head_y),
      .density         (density_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_noise_value (rsp_noise_value)
   );

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives loads of the permutation table and noise evaluations through the
// request channel, predicts each noise value in fixed point and compares it
// with the result channel, across several cell densities.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import pn2d_pkg::*;

   localparam int TSIZE  = 512;
   localparam int FBITS  = 16;
   localparam longint ONE_Q  = 64'sd1 << FBITS;
   localparam longint DIAG_Q = ((64'sd71 << FBITS) + 50) / 100;
   localparam int DRAIN  = COORD_BITS_DEF + FRAC_BITS_DEF + 20;

   // Noise predictor with its own table and density; queue of expected values.
   class noise_scoreboard;
      logic [8:0]  perm [TSIZE];
      logic [15:0] density;
      logic [15:0] pending [$];
      int          errors;

      function new();
         density = DENS_RESET;
         errors = 0;
         foreach (perm[i]) perm[i] = '0;
      endfunction

      function longint fshr(longint v);
         return v >>> FBITS;
      endfunction

      function longint corner(int hin, longint dx, longint dy);
         int h;
         longint mag, gx, gy;
         h = perm[hin % TSIZE] % 8;
         mag = (h < 4) ? DIAG_Q : ONE_Q;
         case (h)
            0: begin gx = -mag; gy = -mag; end
            1: begin gx =  mag; gy = -mag; end
            2: begin gx = -mag; gy =  mag; end
            3: begin gx =  mag; gy =  mag; end
            4: begin gx = -mag; gy = 0; end
            5: begin gx =  mag; gy = 0; end
            6: begin gx = 0; gy =  mag; end
            default: begin gx = 0; gy = -mag; end
         endcase
         return fshr(dx * gx + dy * gy);
      endfunction

      function longint fade(longint t);
         longint p;
         p = fshr((6 * t - 15 * ONE_Q) * t) + 10 * ONE_Q;
         p = fshr(p * t);
         p = fshr(p * t);
         p = fshr(p * t);
         return p;
      endfunction

      function longint lerp(longint w, longint a, longint b);
         return a + fshr(w * (b - a));
      endfunction

      function void note_request(logic cmd, logic [8:0] idx, logic [8:0] val,
                                 logic [15:0] cx, logic [15:0] cy);
         longint d, tx, ty, bl, br, tl, tr, u, v, r;
         int x0, x1, y0, y1, px0, px1;
         if (cmd == CMD_LOAD) begin
            perm[idx] = val;
            return;
         end
         d = (density == 0) ? 1 : density;
         x0 = (cx / d) % TSIZE;
         y0 = (cy / d) % TSIZE;
         x1 = (x0 + 1) % TSIZE;
         y1 = y0 + 1;
         tx = ((cx % d) << FBITS) / d;
         ty = ((cy % d) << FBITS) / d;
         px0 = perm[x0];
         px1 = perm[x1];
         bl = corner(px0 + y0, tx, ty);
         br = corner(px1 + y0, tx - ONE_Q, ty);
         tl = corner(px0 + y1, tx, ty - ONE_Q);
         tr = corner(px1 + y1, tx - ONE_Q, ty - ONE_Q);
         u = fade(tx);
         v = fade(ty);
         r = lerp(u, lerp(v, bl, tl), lerp(v, br, tr)) >>> (FBITS - 15);
         if (r > 32767) r = 32767;
         if (r < -32768) r = -32768;
         pending.push_back(r[15:0]);
      endfunction

      function void check_result(logic [15:0] got);
         logic [15:0] exp_val;
         if (pending.size() == 0) begin
            $error("noise_value: unexpected result %0d", $signed(got));
            errors++;
            return;
         end
         exp_val = pending.pop_front();
         if (got !== exp_val) begin
            $error("noise_value: expected %0d, actual %0d", $signed(exp_val),
                   $signed(got));
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0, req_ready;
   logic        req_command = CMD_LOAD;
   logic [8:0]  req_table_index = '0, req_table_value = '0;
   logic [15:0] req_coord_x = '0, req_coord_y = '0;
   logic        rsp_valid, rsp_ready = 0;
   logic [15:0] rsp_noise_value;
   logic        csr_valid = 0, csr_ready;
   logic [15:0] csr_cell_density = '0;

   noise_scoreboard sb = new();
   int  idle_pct = 8;
   bit  hold_rsp = 0;

   perlin_noise_2d_point_top u_top (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_rsp && hold_left == 0) begin
            hold_left = 300;
            hold_rsp = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_noise_value);
   end

   task automatic send(logic cmd, logic [8:0] idx, logic [8:0] val,
                       logic [15:0] cx, logic [15:0] cy);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_command <= cmd;
      req_table_index <= idx;
      req_table_value <= val;
      req_coord_x <= cx;
      req_coord_y <= cy;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(cmd, idx, val, cx, cy);
      @(negedge clock);
   endtask

   task automatic load_full_table();
      for (int i = 0; i < TSIZE; i++) send(CMD_LOAD, 9'(i), 9'($urandom), '0, '0);
      req_valid <= 0;
   endtask

   task automatic write_density(logic [15:0] dens);
      req_valid <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
      csr_valid <= 1;
      csr_cell_density <= dens;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.density = dens;
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic random_evals(int count, int max_coord);
      for (int i = 0; i < count; i++) begin
         // mostly evaluations, a few reloads of table entries
         if ($urandom_range(9) == 0)
            send(CMD_LOAD, 9'($urandom), 9'($urandom), 16'($urandom), 16'($urandom));
         else
            send(CMD_EVAL, 9'($urandom), 9'($urandom), 16'($urandom_range(max_coord)),
                 16'($urandom_range(max_coord)));
      end
      req_valid <= 0;
   endtask

   initial begin
      logic [15:0] dens_set [6];
      dens_set = '{16'd0, 16'd65535, 16'd7, 16'd256, 16'd33, 16'd3};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // fill every entry before any evaluation reads the table
      load_full_table();
      // directed: default density, corners of coordinate space
      send(CMD_EVAL, '0, '0, 16'h0000, 16'h0000);
      send(CMD_EVAL, '0, '0, 16'hFFFF, 16'hFFFF);
      send(CMD_EVAL, '0, '0, 16'h01FF, 16'h0000);
      send(CMD_EVAL, '0, '0, 16'hAAAA, 16'h5555);
      send(CMD_LOAD, 9'h1FF, 9'h1FF, '0, '0);
      send(CMD_LOAD, 9'h000, 9'h1F8, '0, '0);
      send(CMD_EVAL, '0, '0, 16'h01FF, 16'h01FF);
      write_density(16'd8);
      for (int k = 0; k < 8; k++) send(CMD_EVAL, '0, '0, 16'(k), 16'(7 - k));
      send(CMD_EVAL, '0, '0, 16'hFFFF, 16'h0FFF);

      // fill the pipe while the result side holds off
      req_valid <= 0;
      hold_rsp = 1;
      random_evals(40, 65535);
      idle_pct = 0;
      random_evals(200, 65535);
      idle_pct = 8;

      foreach (dens_set[i]) begin
         write_density(dens_set[i]);
         random_evals(155, 65535);
      end

      req_valid <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
      if (sb.errors == 0)
         $display("perlin_noise_2d_point_top test passed");
      else
         $display("perlin_noise_2d_point_top test failed");
      $finish;
   end

   initial begin
      #400000;
      $display("perlin_noise_2d_point_top test failed");
      $finish;
   end
endmodule
